[hdl/jsu_pkg.sv]
// Shared constants and state types of the Jacobi symbol unit.
package jsu_pkg;

  localparam int DATA_WIDTH = 63;
  localparam int FIELD_W    = 63;
  localparam int S_TDATA_W  = ((2 * FIELD_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = 8;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // Two's complement codes of the symbol field
  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  // Residues of the modulus mod 8 for which a factor of two flips the sign
  localparam logic [2:0] RES8_THREE = 3'd3;
  localparam logic [2:0] RES8_FIVE  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_STEP,
    ST_MOD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_ALIGN,
    MS_REDUCE
  } mod_state_t;

endpackage

[hdl/jsu_mod.sv]
// Multi-cycle remainder unit: align divisor, then shift-and-subtract back down.
module jsu_mod (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [jsu_pkg::DATA_WIDTH-1:0] dividend,
  input  logic [jsu_pkg::DATA_WIDTH-1:0] divisor,
  output logic                           done,
  output logic [jsu_pkg::DATA_WIDTH-1:0] remainder
);

  jsu_pkg::mod_state_t           state, state_next;
  logic [jsu_pkg::DATA_WIDTH-1:0] rem;
  logic [jsu_pkg::DATA_WIDTH-1:0] dsr;
  logic [jsu_pkg::CNT_W-1:0]      shift;
  logic [jsu_pkg::DATA_WIDTH-1:0] dsr_dbl;
  logic [jsu_pkg::DATA_WIDTH-1:0] rem_diff;
  logic                           can_grow;
  logic                           rem_ge;

  assign dsr_dbl  = {dsr[jsu_pkg::DATA_WIDTH-2:0], 1'b0};
  assign can_grow = !dsr[jsu_pkg::DATA_WIDTH-1] && (dsr_dbl <= rem);
  assign rem_ge   = (rem >= dsr);
  assign rem_diff = rem - dsr;
  // Valid alongside done: fold in the subtract of the last reduce cycle
  assign remainder = rem_ge ? rem_diff : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsu_pkg::MS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      jsu_pkg::MS_IDLE: begin
        if (start) state_next = jsu_pkg::MS_ALIGN;
      end
      jsu_pkg::MS_ALIGN: begin
        if (!can_grow) state_next = jsu_pkg::MS_REDUCE;
      end
      jsu_pkg::MS_REDUCE: begin
        if (shift == '0) begin
          state_next = jsu_pkg::MS_IDLE;
          done       = 1'b1;
        end
      end
      default: state_next = jsu_pkg::MS_IDLE;
    endcase
  end

  // Datapath: one compare and at most one subtract per cycle
  always_ff @(posedge clk) begin
    case (state)
      jsu_pkg::MS_IDLE: begin
        if (start) begin
          rem   <= dividend;
          dsr   <= divisor;
          shift <= '0;
        end
      end
      jsu_pkg::MS_ALIGN: begin
        if (can_grow) begin
          dsr   <= dsr_dbl;
          shift <= shift + 1'b1;
        end
      end
      jsu_pkg::MS_REDUCE: begin
        if (rem_ge) rem <= rem_diff;
        if (shift != '0) begin
          dsr   <= dsr >> 1;
          shift <= shift - 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/jacobi_symbol_unit_core.sv]
// Top level of the Jacobi symbol unit: stream ports, sequencer and result register.
//
// Computes the Jacobi symbol (a/b) of a 63-bit numerator a and a 63-bit odd
// modulus b by binary reciprocity, returning -1, 0 or +1 in two's complement.
// An even or zero modulus gives symbol 0 with bad_modulus set. One beat is
// taken at a time: s_tready is high only while the sequencer is idle. The
// sequencer strips one factor of two per cycle, applies the sign rules in its
// step state, then hands (b mod a) to a remainder unit that first doubles
// the divisor up to the dividend (one cycle per quotient bit) and then
// subtracts back down (one more cycle per quotient bit). The result sits in
// an output register, so a new beat may be accepted while the previous
// result waits.
module jacobi_symbol_unit_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata from bit 0: numerator[62:0], modulus[62:0], zero fill
  input  logic [jsu_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata from bit 0: symbol[1:0], bad_modulus, zero fill
  output logic [jsu_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int W = jsu_pkg::DATA_WIDTH;

  jsu_pkg::state_t state, state_next;

  logic [W-1:0] a;          // working numerator
  logic [W-1:0] b;          // working modulus, odd throughout
  logic         twos_odd;   // parity of twos stripped in this step
  logic         sign;       // running sign, set means negative
  logic         bad;        // even or zero modulus seen at entry

  logic         in_beat;
  logic         out_free;
  logic         mod_start;
  logic         mod_done;
  logic [W-1:0] mod_rem;
  logic         flip;
  logic [1:0]   symbol_next;

  logic [W-1:0] num_in;
  logic [W-1:0] mod_in;

  // Take only the low DATA_WIDTH bits of each field
  assign num_in = s_tdata[W-1:0];
  assign mod_in = s_tdata[jsu_pkg::FIELD_W+W-1:jsu_pkg::FIELD_W];

  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Sign flips of one step: odd count of twos against b = 3 or 5 mod 8,
  // then reciprocity when both are 3 mod 4
  assign flip = (twos_odd && (b[2:0] == jsu_pkg::RES8_THREE ||
                              b[2:0] == jsu_pkg::RES8_FIVE))
              ^ (a[1] && b[1]);

  always_comb begin
    if (bad || b != {{(W-1){1'b0}}, 1'b1}) symbol_next = jsu_pkg::SYM_ZERO;
    else if (sign)                          symbol_next = jsu_pkg::SYM_NEG;
    else                                    symbol_next = jsu_pkg::SYM_POS;
  end

  jsu_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (b),
    .divisor   (a),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mod_start  = 1'b0;
    case (state)
      jsu_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (mod_in[0]) state_next = jsu_pkg::ST_STRIP;
          else           state_next = jsu_pkg::ST_DONE;
        end
      end
      jsu_pkg::ST_STRIP: begin
        if (a == '0)    state_next = jsu_pkg::ST_DONE;
        else if (a[0])  state_next = jsu_pkg::ST_STEP;
      end
      jsu_pkg::ST_STEP: begin
        mod_start  = 1'b1;
        state_next = jsu_pkg::ST_MOD;
      end
      jsu_pkg::ST_MOD: begin
        if (mod_done) state_next = jsu_pkg::ST_STRIP;
      end
      jsu_pkg::ST_DONE: begin
        if (out_free) state_next = jsu_pkg::ST_IDLE;
      end
      default: state_next = jsu_pkg::ST_IDLE;
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      jsu_pkg::ST_IDLE: begin
        if (in_beat) begin
          a        <= num_in;
          b        <= mod_in;
          bad      <= !mod_in[0];
          sign     <= 1'b0;
          twos_odd <= 1'b0;
        end
      end
      jsu_pkg::ST_STRIP: begin
        // Drop one factor of two per cycle
        if (a != '0 && !a[0]) begin
          a        <= a >> 1;
          twos_odd <= !twos_odd;
        end
      end
      jsu_pkg::ST_STEP: begin
        sign <= sign ^ flip;
      end
      jsu_pkg::ST_MOD: begin
        // Swap the pair: (a, b) becomes (b mod a, a)
        if (mod_done) begin
          a        <= mod_rem;
          b        <= a;
          twos_odd <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == jsu_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == jsu_pkg::ST_DONE && out_free) begin
      m_tdata <= {{(jsu_pkg::M_TDATA_W-3){1'b0}}, bad, symbol_next};
    end
  end

  // The remainder unit reports completion only while the sequencer waits on it
  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == jsu_pkg::ST_MOD)
    else $error("remainder done outside wait state");

  // The working modulus stays odd through all reduction steps
  a_b_odd: assert property (@(posedge clk) disable iff (rst)
    (state == jsu_pkg::ST_STRIP || state == jsu_pkg::ST_STEP ||
     state == jsu_pkg::ST_MOD) |-> b[0])
    else $error("working modulus became even");

  // A bad modulus always reports symbol zero
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> m_tdata[1:0] == jsu_pkg::SYM_ZERO)
    else $error("bad modulus with nonzero symbol");

  // A new result appears only out of the finishing state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == jsu_pkg::ST_DONE)
    else $error("result raised outside finishing state");

endmodule
